@@ hw/rtl/tsu_pkg.sv @@
// ----------------------------------------------------------------------------
// tsu_pkg
// Shared types and constants of the timer-sampled serial transceiver with
// receive queue.
// ----------------------------------------------------------------------------
package tsu_pkg;

   // receive queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // field widths
   localparam int KIND_W   = 2;
   localparam int WORD_W   = 9;
   localparam int PERIOD_W = 16;
   localparam int LEVEL_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TX_SHIFT_W = 12;
   localparam int RX_SHIFT_W = 11;
   localparam int RX_CNT_W   = 4;

   // register reset values
   localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd372;

   // sample counts that close a frame
   localparam logic [RX_CNT_W:0] FRAME_BITS_8N1 = 5'd10;
   localparam logic [RX_CNT_W:0] FRAME_BITS_9N1 = 5'd11;

   // item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK = 2'd0,
      KIND_SEND = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIT_PERIOD = 2'd0,
      CSR_NINE_BIT   = 2'd1
   } csr_index_type;

   // one result item
   typedef struct packed {
      logic              tx_line;
      logic              tx_busy;
      logic              send_accepted;
      logic [WORD_W-1:0] read_data;
      logic              read_valid;
      logic [LEVEL_W-1:0] fifo_level;
      logic              frame_received;
   } rsp_type;

   // queue requests from the datapath
   typedef struct packed {
      logic rd_req;
      logic wr_req;
   } fifo_ctl_type;

   // queue status after the step
   typedef struct packed {
      logic                  popped;
      logic                  pushed;
      logic [FIFO_CNT_W-1:0] count;
   } fifo_sts_type;

endpackage

@@ hw/rtl/timer_sampled_uart_with_rx_fifo_top.sv @@
// ----------------------------------------------------------------------------
// timer_sampled_uart_with_rx_fifo_top
// Tick-driven 8N1 / 9N1 serial transmitter and receiver with a receive queue.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_kind, req_tx_word, req_rx_level
//  rsp_    | out       | rsp_valid/rsp_stall | tx line, busy, send, read, level, frame
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
//
//  one item per cycle while req_stall is low: each item is one tick, worked in a
//  single pass into the result buffer, which registers its result
//  the phase counter, transmit shifter, receive sampler and queue form a
//  recurrence through their own registers, which sets the rate at one item per clock
//  a two-entry result buffer keeps taking items while a result waits;
//  req_stall rises only when both entries are held
//  synchronous reset clears all control state; the queue words are not cleared
// ----------------------------------------------------------------------------
module timer_sampled_uart_with_rx_fifo_top (
   input  logic                          clock,
   input  logic                          reset,
   // items in
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tsu_pkg::KIND_W-1:0]    req_kind,
   input  logic [tsu_pkg::WORD_W-1:0]    req_tx_word,
   input  logic                          req_rx_level,
   // results out
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_tx_line,
   output logic                          rsp_tx_busy,
   output logic                          rsp_send_accepted,
   output logic [tsu_pkg::WORD_W-1:0]    rsp_read_data,
   output logic                          rsp_read_valid,
   output logic [tsu_pkg::LEVEL_W-1:0]   rsp_fifo_level,
   output logic                          rsp_frame_received,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tsu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tsu_pkg::CSR_DATA_W-1:0] csr_data
);
   import tsu_pkg::*;

   // configuration
   logic [PERIOD_W-1:0]   bit_period_ff;
   logic                  nine_bit_ff;

   // tick state
   logic [PERIOD_W-1:0]   phase_ff, phase_in;
   logic [TX_SHIFT_W-1:0] tx_shift_ff, tx_shift_in;
   logic                  tx_level_ff, tx_level_in;
   logic                  rx_active_ff, rx_active_in;
   logic [PERIOD_W-1:0]   rx_phase_ff, rx_phase_in;
   logic [RX_SHIFT_W-1:0] rx_shift_ff, rx_shift_in;
   logic [RX_CNT_W-1:0]   rx_cnt_ff, rx_cnt_in;
   logic                  rx_prev_ff, rx_prev_in;

   logic                  accept;
   logic                  wrap;
   logic                  send_ok;
   logic [WORD_W-1:0]     tx_data;
   logic [RX_SHIFT_W-1:0] rx_data;
   logic [RX_CNT_W:0]     rx_bits;
   logic                  rx_stop;
   logic                  frame_ok;
   logic [PERIOD_W:0]     arm_sum;
   logic [PERIOD_W:0]     arm_wrap;
   logic [PERIOD_W:0]     period_ext;
   logic [PERIOD_W-1:0]   arm_phase;

   fifo_ctl_type          fifo_ctl;
   fifo_sts_type          fifo_sts;
   logic [WORD_W-1:0]     fifo_rd_word;
   logic [WORD_W-1:0]     fifo_wr_word;
   logic [FIFO_CNT_W+LEVEL_W-1:0] level_ext;
   rsp_type               rsp_in;
   rsp_type               rsp_out;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= BIT_PERIOD_RESET;
         nine_bit_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BIT_PERIOD: bit_period_ff <= csr_data[PERIOD_W-1:0];
            CSR_NINE_BIT:   nine_bit_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // transmit: shift on wrap, then load a send when idle before the shift
   always_comb begin
      wrap        = (phase_ff >= bit_period_ff);
      tx_shift_in = tx_shift_ff;
      tx_level_in = tx_level_ff;
      if (wrap && (tx_shift_ff != '0)) begin
         tx_level_in = tx_shift_ff[0];
         tx_shift_in = tx_shift_ff >> 1;
      end
      send_ok = (kind_type'(req_kind) == KIND_SEND) && (tx_shift_ff == '0);
      tx_data = nine_bit_ff ? req_tx_word : {1'b0, req_tx_word[7:0]};
      if (send_ok) begin
         tx_shift_in = nine_bit_ff ? {2'b11, tx_data, 1'b0}
                                   : {1'b0, 2'b11, tx_data[7:0], 1'b0};
      end
   end

   // arming phase: edge phase plus half a period, folded into the period
   always_comb begin
      period_ext = {1'b0, bit_period_ff};
      arm_sum    = {1'b0, phase_ff} + {2'b00, bit_period_ff[PERIOD_W-1:1]};
      arm_wrap   = (arm_sum >= period_ext) ? (arm_sum - period_ext) : arm_sum;
      arm_phase  = (arm_wrap >= period_ext) ? '0 : arm_wrap[PERIOD_W-1:0];
   end

   // receive: sample on the armed phase or arm on a falling edge
   always_comb begin
      rx_active_in = rx_active_ff;
      rx_phase_in  = rx_phase_ff;
      rx_shift_in  = rx_shift_ff;
      rx_cnt_in    = rx_cnt_ff;
      rx_data      = {1'b0, rx_shift_ff[RX_SHIFT_W-1:1]};
      if (req_rx_level) begin
         if (nine_bit_ff) begin
            rx_data[10] = 1'b1;
         end else begin
            rx_data[9] = 1'b1;
         end
      end
      rx_bits  = {1'b0, rx_cnt_ff} + {{RX_CNT_W{1'b0}}, 1'b1};
      rx_stop  = nine_bit_ff ? rx_data[10] : rx_data[9];
      frame_ok = 1'b0;
      if (rx_active_ff) begin
         if (phase_ff == rx_phase_ff) begin
            if (rx_bits >= (nine_bit_ff ? FRAME_BITS_9N1 : FRAME_BITS_8N1)) begin
               frame_ok     = !rx_data[0] && rx_stop;
               rx_active_in = 1'b0;
               rx_cnt_in    = '0;
               rx_shift_in  = '0;
            end else begin
               rx_cnt_in   = rx_bits[RX_CNT_W-1:0];
               rx_shift_in = rx_data;
            end
         end
      end else if (rx_prev_ff && !req_rx_level) begin
         rx_phase_in  = arm_phase;
         rx_active_in = 1'b1;
         rx_shift_in  = '0;
         rx_cnt_in    = '0;
      end
      rx_prev_in   = req_rx_level;
      fifo_wr_word = rx_data[9:1];
      phase_in     = wrap ? '0 : (phase_ff + PERIOD_W'(1));
   end

   // receive queue
   assign fifo_ctl.rd_req = (kind_type'(req_kind) == KIND_READ);
   assign fifo_ctl.wr_req = frame_ok;

   tsu_rx_fifo u_rx_fifo (
      .clock   (clock),
      .reset   (reset),
      .en      (accept),
      .ctl     (fifo_ctl),
      .wr_word (fifo_wr_word),
      .rd_word (fifo_rd_word),
      .sts     (fifo_sts)
   );

   // result item
   always_comb begin
      level_ext             = {{LEVEL_W{1'b0}}, fifo_sts.count};
      rsp_in.tx_line        = tx_level_in;
      rsp_in.tx_busy        = (tx_shift_in != '0);
      rsp_in.send_accepted  = send_ok;
      rsp_in.read_data      = '0;
      if (fifo_sts.popped) begin
         rsp_in.read_data = nine_bit_ff ? fifo_rd_word : {1'b0, fifo_rd_word[7:0]};
      end
      rsp_in.read_valid     = fifo_sts.popped;
      rsp_in.fifo_level     = level_ext[LEVEL_W-1:0];
      rsp_in.frame_received = fifo_sts.pushed;
   end

   // tick state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         tx_shift_ff  <= '0;
         tx_level_ff  <= 1'b1;
         rx_active_ff <= 1'b0;
         rx_phase_ff  <= '0;
         rx_shift_ff  <= '0;
         rx_cnt_ff    <= '0;
         rx_prev_ff   <= 1'b1;
      end else if (accept) begin
         phase_ff     <= phase_in;
         tx_shift_ff  <= tx_shift_in;
         tx_level_ff  <= tx_level_in;
         rx_active_ff <= rx_active_in;
         rx_phase_ff  <= rx_phase_in;
         rx_shift_ff  <= rx_shift_in;
         rx_cnt_ff    <= rx_cnt_in;
         rx_prev_ff   <= rx_prev_in;
      end
   end

   // result buffer
   tsu_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_push   (accept),
      .in_item   (rsp_in),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_item  (rsp_out),
      .out_stall (rsp_stall)
   );

   assign rsp_tx_line        = rsp_out.tx_line;
   assign rsp_tx_busy        = rsp_out.tx_busy;
   assign rsp_send_accepted  = rsp_out.send_accepted;
   assign rsp_read_data      = rsp_out.read_data;
   assign rsp_read_valid     = rsp_out.read_valid;
   assign rsp_fifo_level     = rsp_out.fifo_level;
   assign rsp_frame_received = rsp_out.frame_received;

   a_rx_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !rx_active_ff |-> ((rx_cnt_ff == '0) && (rx_shift_ff == '0)))
      else $error("idle receiver holds frame state");

   a_rx_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rx_cnt_ff <= RX_CNT_W'(10))
      else $error("receive sample count beyond frame length");

   a_send_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && send_ok) |=> (tx_shift_ff != '0))
      else $error("accepted send left the shifter idle");

   a_frame_level: assert property (@(posedge clock) disable iff (reset)
      (accept && fifo_sts.pushed) |-> (fifo_sts.count != '0))
      else $error("stored frame with empty queue");

endmodule

@@ hw/rtl/tsu_rx_fifo.sv @@
// ----------------------------------------------------------------------------
// tsu_rx_fifo
// Receive word queue: pop first, then push into the room left after the pop.
// ----------------------------------------------------------------------------
module tsu_rx_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  tsu_pkg::fifo_ctl_type    ctl,
   input  logic [tsu_pkg::WORD_W-1:0] wr_word,
   output logic [tsu_pkg::WORD_W-1:0] rd_word,
   output tsu_pkg::fifo_sts_type    sts
);
   import tsu_pkg::*;

   logic [WORD_W-1:0]     mem [FIFO_DEPTH];
   logic [FIFO_IDX_W-1:0] head_ff, head_in;
   logic [FIFO_IDX_W-1:0] tail_ff, tail_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_CNT_W-1:0] count_mid;
   logic                  pop;
   logic                  push;

   function automatic logic [FIFO_IDX_W-1:0] next_index(input logic [FIFO_IDX_W-1:0] i);
      if (i == FIFO_IDX_W'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return i + FIFO_IDX_W'(1);
   endfunction

   // oldest word, read at the tail
   assign rd_word = mem[tail_ff];

   // pop then push decisions
   always_comb begin
      pop       = en && ctl.rd_req && (count_ff != '0);
      count_mid = count_ff - FIFO_CNT_W'(pop);
      push      = en && ctl.wr_req && (count_mid < FIFO_CNT_W'(FIFO_DEPTH));
      count_in  = count_mid + FIFO_CNT_W'(push);
      head_in   = push ? next_index(head_ff) : head_ff;
      tail_in   = pop ? next_index(tail_ff) : tail_ff;
      sts.popped = pop;
      sts.pushed = push;
      sts.count  = count_in;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[head_ff] <= wr_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("receive queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with pointers apart");

   a_pop_step: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - FIFO_CNT_W'(1)))
      else $error("pop did not lower the count");

endmodule

@@ hw/rtl/tsu_rsp_buf.sv @@
// ----------------------------------------------------------------------------
// tsu_rsp_buf
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module tsu_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_push,
   input  tsu_pkg::rsp_type  in_item,
   output logic              in_stall,
   output logic              out_valid,
   output tsu_pkg::rsp_type  out_item,
   input  logic              out_stall
);
   import tsu_pkg::*;

   rsp_type    head_ff, head_in;
   rsp_type    spare_ff, spare_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = head_ff;
   assign in_stall  = (count_ff == 2'd2);
   assign pop       = out_valid && !out_stall;

   // occupancy update
   always_comb begin
      head_in  = head_ff;
      spare_in = spare_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (in_push) begin
               head_in  = in_item;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (pop && in_push) begin
               head_in = in_item;
            end else if (pop) begin
               count_in = 2'd0;
            end else if (in_push) begin
               spare_in = in_item;
               count_in = 2'd2;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = spare_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

endmodule
